@@ rtl/ndefrp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// NDEF record parser package
// Shared widths, header flag bits, result status codes and helpers.
// ---------------------------------------------------------------------------
package ndefrp_pkg;

   // Default size of the message buffer in bytes
   localparam longint unsigned BUFFER_BYTES_DEF = 64'd65536;

   // Record limit after reset
   localparam logic [7:0] MAX_RECORDS_RST = 8'd16;

   // Width of the remaining-bytes counter (type + id + payload lengths)
   localparam int unsigned SKIP_W = 33;

   // Record header flag bit positions
   localparam int unsigned FLAG_MB = 7;
   localparam int unsigned FLAG_ME = 6;
   localparam int unsigned FLAG_SR = 4;
   localparam int unsigned FLAG_IL = 3;

   // Result status codes
   typedef enum logic [1:0] {
      ST_RECORD    = 2'd0,
      ST_FINAL     = 2'd1,
      ST_FMT_ERR   = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

   // Clamp an offset to 16 bits
   function automatic logic [15:0] sat16(input logic [63:0] v);
      logic [15:0] r;
      r = (v[63:16] != '0) ? 16'hFFFF : v[15:0];
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/ndef_record_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// NDEF record parser
// Walks an NDEF message one byte per word, decodes each record header,
// reports lengths and offsets per record and checks the MB/ME/count rules and the buffer bound.
// ---------------------------------------------------------------------------
//  Channel   Dir   Handshake           Contents
//  req_      in    tvalid/tready       tdata: data_byte; tlast: last_byte
//  rsp_      out   tvalid/tready       tuser: status; tdata: record fields
//  csr_      in    we (no wait)        wdata: max_records
//
//  One input word per cycle; the header decoder and offset adders sit
//  between the parser state registers and the result register.
//  A result is registered and appears in the cycle after the word that completes it.
//  The input stalls only while a result is held and rsp_tready is low.
//  Synchronous reset clears the parser state and sets max_records to 16.
// ---------------------------------------------------------------------------
module ndef_record_parser #(
   parameter longint unsigned BUFFER_BYTES = ndefrp_pkg::BUFFER_BYTES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // input stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tlast,   // last_byte
   // result stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // [7:0] record_index, [15:8] header_flags,
                                          // [23:16] type_length, [31:24] id_length,
                                          // [63:32] payload_length, [79:64] type_offset,
                                          // [95:80] id_offset, [111:96] payload_offset,
                                          // [127:112] end_offset
   output logic [1:0]        rsp_tuser,   // [1:0] status
   // configuration
   input  wire logic         csr_we,
   input  wire logic [7:0]   csr_wdata    // max_records
);

   // Byte position must reach a little past the end of the buffer
   localparam int unsigned POS_W = $clog2(BUFFER_BYTES + 64'd16);
   localparam int unsigned OFF_W = ((POS_W > 32) ? POS_W : 32) + 3;
   localparam int unsigned SKIP_W = ndefrp_pkg::SKIP_W;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TYPELEN,
      PH_PAYLEN,
      PH_IDLEN,
      PH_SKIP
   } phase_type;

   // Parser state
   phase_type           phase_ff, phase_in;
   logic [7:0]          hdr_ff, hdr_in;
   logic [7:0]          tlen_ff, tlen_in;
   logic [7:0]          ilen_ff, ilen_in;
   logic [31:0]         plen_ff, plen_in;
   logic [1:0]          lcnt_ff, lcnt_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [SKIP_W-1:0]   skip_ff, skip_in;
   logic [7:0]          recs_ff, recs_in;
   logic                done_ff, done_in;
   logic [7:0]          max_recs_ff;

   // Result register
   logic                rsp_valid_ff;
   logic                rsp_load;
   logic [1:0]          rsp_status_in, rsp_status_ff;
   logic [127:0]        rsp_data_in, rsp_data_ff;

   logic                req_fire;
   logic                partial;
   logic                finish;
   logic [1:0]          fin_status;
   logic [OFF_W-1:0]    t_off, i_off, p_off, e_off;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Decode one byte and build the next state and result
   always_comb begin
      phase_in      = phase_ff;
      hdr_in        = hdr_ff;
      tlen_in       = tlen_ff;
      ilen_in       = ilen_ff;
      plen_in       = plen_ff;
      lcnt_in       = lcnt_ff;
      pos_in        = pos_ff;
      skip_in       = skip_ff;
      recs_in       = recs_ff;
      done_in       = done_ff;
      rsp_load      = 1'b0;
      rsp_status_in = ndefrp_pkg::ST_RECORD;
      rsp_data_in   = '0;
      partial       = 1'b0;
      finish        = 1'b0;
      fin_status    = ndefrp_pkg::ST_RECORD;
      t_off         = '0;
      i_off         = '0;
      p_off         = '0;
      e_off         = '0;

      if (req_fire && !done_ff) begin
         pos_in = pos_ff + POS_W'(1);
         unique case (phase_ff)
            PH_HEADER: begin
               hdr_in   = req_tdata;
               tlen_in  = '0;
               ilen_in  = '0;
               plen_in  = '0;
               lcnt_in  = '0;
               phase_in = PH_TYPELEN;
               partial  = 1'b1;
            end
            PH_TYPELEN: begin
               tlen_in  = req_tdata;
               phase_in = PH_PAYLEN;
               partial  = 1'b1;
            end
            PH_PAYLEN: begin
               plen_in = {plen_ff[23:0], req_tdata};
               if (hdr_ff[ndefrp_pkg::FLAG_SR] || lcnt_ff == 2'd3) begin
                  lcnt_in = '0;
                  if (hdr_ff[ndefrp_pkg::FLAG_IL]) begin
                     phase_in = PH_IDLEN;
                     partial  = 1'b1;
                  end else begin
                     finish = 1'b1;
                  end
               end else begin
                  lcnt_in = lcnt_ff + 2'd1;
                  partial = 1'b1;
               end
            end
            PH_IDLEN: begin
               ilen_in = req_tdata;
               finish  = 1'b1;
            end
            PH_SKIP: begin
               skip_in = skip_ff - SKIP_W'(1);
               if (skip_ff == SKIP_W'(1)) begin
                  phase_in = PH_HEADER;
               end
               // buffer ended inside the record body
               if (req_tlast) begin
                  rsp_load           = 1'b1;
                  rsp_status_in      = ndefrp_pkg::ST_FMT_ERR;
                  rsp_data_in[7:0]   = recs_ff;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase

         // Buffer ended before the header was complete
         if (partial && req_tlast) begin
            rsp_load            = 1'b1;
            rsp_status_in       = ndefrp_pkg::ST_TRUNCATED;
            rsp_data_in[7:0]    = recs_ff;
            rsp_data_in[15:8]   = hdr_in;
            rsp_data_in[23:16]  = tlen_in;
            rsp_data_in[31:24]  = ilen_in;
            rsp_data_in[63:32]  = plen_in;
         end

         // Header complete: offsets, rule checks and report
         if (finish) begin
            t_off = OFF_W'(pos_ff) + OFF_W'(1);
            i_off = t_off + OFF_W'(tlen_in);
            p_off = i_off + OFF_W'(ilen_in);
            e_off = p_off + OFF_W'(plen_in);
            priority if (recs_ff == 8'd0 && !hdr_in[ndefrp_pkg::FLAG_MB]) begin
               fin_status = ndefrp_pkg::ST_FMT_ERR;
            end else if (recs_ff != 8'd0 && hdr_in[ndefrp_pkg::FLAG_MB]) begin
               fin_status = ndefrp_pkg::ST_FMT_ERR;
            end else if (recs_ff >= max_recs_ff) begin
               fin_status = ndefrp_pkg::ST_FMT_ERR;
            end else if (e_off > OFF_W'(BUFFER_BYTES)) begin
               fin_status = ndefrp_pkg::ST_TRUNCATED;
            end else if (hdr_in[ndefrp_pkg::FLAG_ME]) begin
               fin_status = ndefrp_pkg::ST_FINAL;
            end else if (req_tlast) begin
               fin_status = ndefrp_pkg::ST_FMT_ERR;
            end else begin
               fin_status = ndefrp_pkg::ST_RECORD;
            end

            rsp_load             = 1'b1;
            rsp_status_in        = fin_status;
            rsp_data_in[7:0]     = recs_ff;
            rsp_data_in[15:8]    = hdr_in;
            rsp_data_in[23:16]   = tlen_in;
            rsp_data_in[31:24]   = ilen_in;
            rsp_data_in[63:32]   = plen_in;
            rsp_data_in[79:64]   = ndefrp_pkg::sat16(64'(t_off));
            rsp_data_in[95:80]   = ndefrp_pkg::sat16(64'(i_off));
            rsp_data_in[111:96]  = ndefrp_pkg::sat16(64'(p_off));
            rsp_data_in[127:112] = ndefrp_pkg::sat16(64'(e_off));

            if (!req_tlast) begin
               if (fin_status == ndefrp_pkg::ST_RECORD) begin
                  recs_in  = recs_ff + 8'd1;
                  skip_in  = SKIP_W'(tlen_in) + SKIP_W'(ilen_in) + SKIP_W'(plen_in);
                  phase_in = (skip_in != '0) ? PH_SKIP : PH_HEADER;
               end else begin
                  done_in = 1'b1;
               end
            end
         end
      end

      // A last word always starts a fresh message
      if (req_fire && req_tlast) begin
         phase_in = PH_HEADER;
         hdr_in   = '0;
         tlen_in  = '0;
         ilen_in  = '0;
         plen_in  = '0;
         lcnt_in  = '0;
         pos_in   = '0;
         skip_in  = '0;
         recs_in  = '0;
         done_in  = 1'b0;
      end
   end

   // Hold parser state, configuration and result
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_ff       <= '0;
         tlen_ff      <= '0;
         ilen_ff      <= '0;
         plen_ff      <= '0;
         lcnt_ff      <= '0;
         pos_ff       <= '0;
         skip_ff      <= '0;
         recs_ff      <= '0;
         done_ff      <= 1'b0;
         max_recs_ff  <= ndefrp_pkg::MAX_RECORDS_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         tlen_ff  <= tlen_in;
         ilen_ff  <= ilen_in;
         plen_ff  <= plen_in;
         lcnt_ff  <= lcnt_in;
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         recs_ff  <= recs_in;
         done_ff  <= done_in;
         if (csr_we) begin
            max_recs_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   // Skipping always has bytes left to drop
   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (skip_ff != '0))
      else $error("skip phase with empty byte count");

   // Bytes of a finished message never produce a result
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && done_ff) |-> !rsp_load)
      else $error("result produced after message end");

   // A last word restarts the parser
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (pos_ff == '0 && recs_ff == 8'd0 && !done_ff
                                   && phase_ff == PH_HEADER))
      else $error("parser not restarted after last word");

endmodule
`default_nettype wire
